FILE: rtl/ctls_pkg.sv
// Shared types and constants of the crossing traffic light sequencer.
`default_nettype none

package ctls_pkg;

   localparam int TICK_W       = 16;
   localparam int DUTY_W       = 11;
   localparam int POT_IN_W     = 12;
   localparam int POT_BITS     = 12;
   localparam int FLASH_PERIOD = 10;
   localparam int FLASH_W      = $clog2(FLASH_PERIOD);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_TICKS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBER_TICKS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WALK_RED_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAIN_RED_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_CLOSED     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_OPEN       = 3'd5;

   localparam logic [TICK_W-1:0] GREEN_TICKS_RST     = 16'd100;
   localparam logic [TICK_W-1:0] AMBER_TICKS_RST     = 16'd30;
   localparam logic [TICK_W-1:0] WALK_RED_TICKS_RST  = 16'd100;
   localparam logic [TICK_W-1:0] PLAIN_RED_TICKS_RST = 16'd30;
   localparam logic [DUTY_W-1:0] DUTY_CLOSED_RST     = 11'd550;
   localparam logic [DUTY_W-1:0] DUTY_OPEN_RST       = 11'd1025;
   localparam logic [DUTY_W-1:0] DUTY_RST            = 11'd750;

   typedef enum logic [3:0] {
      PH_RED     = 4'd0,
      PH_YEL1    = 4'd1,
      PH_GREEN   = 4'd2,
      PH_YEL2    = 4'd3,
      PH_CLOSING = 4'd4,
      PH_CLOSED  = 4'd5,
      PH_OPENING = 4'd6,
      PH_WAIT    = 4'd7,
      PH_MAINT   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      LAMP_OFF    = 2'd0,
      LAMP_RED    = 2'd1,
      LAMP_YELLOW = 2'd2,
      LAMP_GREEN  = 2'd3
   } lamp_type;

   typedef logic [POT_BITS-1:0] pot_type;

   typedef struct packed {
      logic                tick;
      logic                ped_button;
      logic                train_present;
      logic                maintenance_on;
      logic [POT_IN_W-1:0] pot_sample;
   } req_item_type;

   typedef struct packed {
      phase_type         phase;
      lamp_type          lamp;
      logic              walk_led;
      logic [DUTY_W-1:0] gate_duty;
      logic              flash_led;
   } rsp_item_type;

   typedef struct packed {
      logic [TICK_W-1:0] green_ticks;
      logic [TICK_W-1:0] amber_ticks;
      logic [TICK_W-1:0] walk_red_ticks;
      logic [TICK_W-1:0] plain_red_ticks;
      logic [DUTY_W-1:0] duty_closed;
      logic [DUTY_W-1:0] duty_open;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/ctls_csr_regs.sv
// Configuration registers of the sequencer, write only.
`default_nettype none

module ctls_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ctls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctls_pkg::CSR_DATA_W-1:0] csr_wdata,
   output ctls_pkg::cfg_type               cfg
);

   ctls_pkg::cfg_type cfg_ff;
   ctls_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ctls_pkg::CSR_GREEN_TICKS:     cfg_in.green_ticks     = csr_wdata;
            ctls_pkg::CSR_AMBER_TICKS:     cfg_in.amber_ticks     = csr_wdata;
            ctls_pkg::CSR_WALK_RED_TICKS:  cfg_in.walk_red_ticks  = csr_wdata;
            ctls_pkg::CSR_PLAIN_RED_TICKS: cfg_in.plain_red_ticks = csr_wdata;
            ctls_pkg::CSR_DUTY_CLOSED:
               cfg_in.duty_closed = csr_wdata[ctls_pkg::DUTY_W-1:0];
            ctls_pkg::CSR_DUTY_OPEN:
               cfg_in.duty_open = csr_wdata[ctls_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_ticks     <= ctls_pkg::GREEN_TICKS_RST;
         cfg_ff.amber_ticks     <= ctls_pkg::AMBER_TICKS_RST;
         cfg_ff.walk_red_ticks  <= ctls_pkg::WALK_RED_TICKS_RST;
         cfg_ff.plain_red_ticks <= ctls_pkg::PLAIN_RED_TICKS_RST;
         cfg_ff.duty_closed     <= ctls_pkg::DUTY_CLOSED_RST;
         cfg_ff.duty_open       <= ctls_pkg::DUTY_OPEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/ctls_pot_map.sv
// Linear pot-to-duty mapping with rounding, divide by 2^n-1 done by folding.
`default_nettype none

module ctls_pot_map (
   input  logic [ctls_pkg::POT_IN_W-1:0] pot_sample,
   input  logic [ctls_pkg::DUTY_W-1:0]   duty_closed,
   input  logic [ctls_pkg::DUTY_W-1:0]   duty_open,
   output logic [ctls_pkg::DUTY_W-1:0]   pot_duty
);

   localparam int PB    = ctls_pkg::POT_BITS;
   localparam int DW    = ctls_pkg::DUTY_W;
   localparam int NUM_W = DW + PB + 1;
   localparam int A_W   = NUM_W - PB;
   localparam int SUM_W = ((A_W > PB) ? A_W : PB) + 1;
   localparam logic [NUM_W-1:0] HALF_FULL = NUM_W'((2 ** PB - 1) / 2);
   localparam logic [SUM_W-1:0] FULL      = SUM_W'(2 ** PB - 1);

   ctls_pkg::pot_type p;
   ctls_pkg::pot_type p_inv;
   logic [NUM_W-1:0]  prod_closed;
   logic [NUM_W-1:0]  prod_open;
   logic [NUM_W-1:0]  num;
   logic [A_W-1:0]    a1;
   logic [SUM_W-1:0]  s1;
   logic [SUM_W-1:0]  a2;
   logic [SUM_W-1:0]  s2;
   logic [SUM_W-1:0]  quot;

   // full scale is all ones, so full - p is the complement of p
   assign p           = ctls_pkg::pot_type'(pot_sample);
   assign p_inv       = ~p;
   assign prod_closed = NUM_W'(duty_closed) * NUM_W'(p_inv);
   assign prod_open   = NUM_W'(duty_open) * NUM_W'(p);
   assign num         = prod_closed + prod_open + HALF_FULL;

   // x = a*2^n + b = a*(2^n-1) + (a+b); fold twice, then one compare
   assign a1   = num[NUM_W-1:PB];
   assign s1   = SUM_W'(a1) + SUM_W'(num[PB-1:0]);
   assign a2   = s1 >> PB;
   assign s2   = a2 + SUM_W'(s1[PB-1:0]);
   assign quot = SUM_W'(a1) + a2 + SUM_W'(s2 >= FULL);

   assign pot_duty = quot[DW-1:0];

endmodule

`default_nettype wire

FILE: rtl/ctls_seq_core.sv
// Phase machine with timers, walk latch, lamp, gate duty and flash LED state.
`default_nettype none

module ctls_seq_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  ctls_pkg::req_item_type         item,
   input  ctls_pkg::cfg_type              cfg,
   input  logic [ctls_pkg::DUTY_W-1:0]    pot_duty,
   output ctls_pkg::rsp_item_type         rsp
);

   localparam int TW = ctls_pkg::TICK_W;
   localparam int FW = ctls_pkg::FLASH_W;
   localparam logic [FW:0] FLASH_WRAP = (FW + 1)'(ctls_pkg::FLASH_PERIOD);

   ctls_pkg::phase_type           phase_ff, phase_in;
   logic [TW-1:0]                 tick_ff, tick_in;
   logic                          pend_ff, pend_in;
   ctls_pkg::lamp_type            lamp_ff, lamp_in;
   logic                          walk_ff, walk_in;
   logic [ctls_pkg::DUTY_W-1:0]   duty_ff, duty_in;
   logic [FW-1:0]                 fcount_ff, fcount_in;
   logic                          flash_ff, flash_in;

   logic                          maint_entry;
   logic                          train_entry;
   logic [TW-1:0]                 tick_inc;
   logic [TW-1:0]                 tc;
   logic                          pend;
   ctls_pkg::phase_type           ph;
   logic                          leave;
   logic [FW:0]                   fcount_plus;

   assign tick_inc = (item.tick && (tick_ff != {TW{1'b1}})) ? tick_ff + 1'b1 : tick_ff;
   assign pend     = pend_ff | item.ped_button;

   assign maint_entry = item.maintenance_on && (phase_ff != ctls_pkg::PH_MAINT);
   assign train_entry = !maint_entry && item.train_present
                        && (phase_ff < ctls_pkg::PH_CLOSING);

   always_comb begin
      if (maint_entry) begin
         ph = ctls_pkg::PH_MAINT;
      end else if (train_entry) begin
         ph = ctls_pkg::PH_CLOSING;
      end else begin
         ph = phase_ff;
      end
   end

   assign tc = (maint_entry || train_entry) ? '0 : tick_inc;

   // next phase and timer
   always_comb begin
      phase_in = ph;
      leave    = 1'b0;
      unique case (ph)
         ctls_pkg::PH_RED: begin
            leave    = tc >= (pend ? cfg.walk_red_ticks : cfg.plain_red_ticks);
            phase_in = leave ? ctls_pkg::PH_YEL1 : ph;
         end
         ctls_pkg::PH_YEL1: begin
            leave    = tc >= cfg.amber_ticks;
            phase_in = leave ? ctls_pkg::PH_GREEN : ph;
         end
         ctls_pkg::PH_GREEN: begin
            leave    = tc >= cfg.green_ticks;
            phase_in = leave ? ctls_pkg::PH_YEL2 : ph;
         end
         ctls_pkg::PH_YEL2: begin
            leave    = tc >= cfg.amber_ticks;
            phase_in = leave ? ctls_pkg::PH_RED : ph;
         end
         ctls_pkg::PH_CLOSING: begin
            leave    = 1'b1;
            phase_in = ctls_pkg::PH_CLOSED;
         end
         ctls_pkg::PH_CLOSED: begin
            leave    = !item.train_present;
            phase_in = leave ? ctls_pkg::PH_OPENING : ph;
         end
         ctls_pkg::PH_OPENING: begin
            leave    = 1'b1;
            phase_in = ctls_pkg::PH_WAIT;
         end
         ctls_pkg::PH_WAIT: begin
            leave    = tc >= cfg.walk_red_ticks;
            phase_in = leave ? ctls_pkg::PH_YEL1 : ph;
         end
         ctls_pkg::PH_MAINT: begin
            leave    = !item.maintenance_on;
            phase_in = leave ? ctls_pkg::PH_RED : ph;
         end
         default: begin
            leave    = 1'b1;
            phase_in = ctls_pkg::PH_RED;
         end
      endcase
      tick_in = leave ? '0 : tc;
   end

   assign fcount_plus = {1'b0, fcount_ff} + 1'b1;

   // lamp, walk, duty, walk latch and flash
   always_comb begin
      lamp_in = lamp_ff;
      walk_in = walk_ff;
      duty_in = maint_entry ? cfg.duty_closed : duty_ff;
      pend_in = pend;
      unique case (ph) inside
         ctls_pkg::PH_RED: begin
            lamp_in = ctls_pkg::LAMP_RED;
            duty_in = cfg.duty_open;
            walk_in = pend && !leave;
            pend_in = pend && !leave;
         end
         ctls_pkg::PH_YEL1, ctls_pkg::PH_YEL2: begin
            lamp_in = ctls_pkg::LAMP_YELLOW;
         end
         ctls_pkg::PH_GREEN: begin
            lamp_in = ctls_pkg::LAMP_GREEN;
            duty_in = cfg.duty_open;
         end
         ctls_pkg::PH_CLOSING: begin
            lamp_in = ctls_pkg::LAMP_RED;
            duty_in = cfg.duty_closed;
         end
         ctls_pkg::PH_CLOSED: begin
            walk_in = 1'b1;
         end
         ctls_pkg::PH_OPENING: begin
            duty_in = cfg.duty_open;
         end
         ctls_pkg::PH_WAIT: begin
            walk_in = !leave;
         end
         ctls_pkg::PH_MAINT: begin
            lamp_in = ctls_pkg::LAMP_OFF;
            walk_in = item.maintenance_on;
            duty_in = (tc == '0) ? cfg.duty_closed : pot_duty;
         end
         default: ;
      endcase

      flash_in = flash_ff;
      if (item.maintenance_on && (fcount_ff == '0)) begin
         lamp_in  = ctls_pkg::LAMP_OFF;
         flash_in = !flash_ff;
      end
      fcount_in = (fcount_plus >= FLASH_WRAP) ? '0 : fcount_plus[FW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ctls_pkg::PH_RED;
         tick_ff   <= '0;
         pend_ff   <= 1'b0;
         lamp_ff   <= ctls_pkg::LAMP_OFF;
         walk_ff   <= 1'b0;
         duty_ff   <= ctls_pkg::DUTY_RST;
         fcount_ff <= '0;
         flash_ff  <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         pend_ff   <= pend_in;
         lamp_ff   <= lamp_in;
         walk_ff   <= walk_in;
         duty_ff   <= duty_in;
         fcount_ff <= fcount_in;
         flash_ff  <= flash_in;
      end
   end

   assign rsp.phase     = phase_ff;
   assign rsp.lamp      = lamp_ff;
   assign rsp.walk_led  = walk_ff;
   assign rsp.gate_duty = duty_ff;
   assign rsp.flash_led = flash_ff;

endmodule

`default_nettype wire

FILE: rtl/crossing_traffic_light_sequencer.sv
// Top level of the crossing traffic light sequencer: input register, handshake, CSRs.
`default_nettype none

// One evaluation step per item, one item per clock sustained while results are
// taken. An accepted item sits in the input register and is evaluated in a
// single pass through the phase machine and pot mapping, whose state registers
// form the result register that offers the result. While a result waits, one
// further item is still taken into the input register. CSR writes take effect
// on the next clock and should be made with the block idle.
module crossing_traffic_light_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ctls_pkg::req_item_type          req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ctls_pkg::rsp_item_type          rsp_item,
   input  logic                             csr_we,
   input  logic [ctls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctls_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                          in_valid_ff, in_valid_in;
   ctls_pkg::req_item_type        item_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          step;
   logic                          req_take;
   ctls_pkg::cfg_type             cfg;
   logic [ctls_pkg::DUTY_W-1:0]   pot_duty;

   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   ctls_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ctls_pot_map u_pot_map (
      .pot_sample  (item_ff.pot_sample),
      .duty_closed (cfg.duty_closed),
      .duty_open   (cfg.duty_open),
      .pot_duty    (pot_duty)
   );

   ctls_seq_core u_seq_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (item_ff),
      .cfg      (cfg),
      .pot_duty (pot_duty),
      .rsp      (rsp_item)
   );

endmodule

`default_nettype wire

FILE: tb/crossing_traffic_light_sequencer_tb.sv
// Self-checking testbench of the crossing traffic light sequencer: predicted lights per item.
`timescale 1ns / 100ps

module crossing_traffic_light_sequencer_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ctls_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ctls_pkg::rsp_item_type rsp_item;
   logic csr_we = 1'b0;
   logic [ctls_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ctls_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   crossing_traffic_light_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // predicted state of the sequencer
   ctls_pkg::cfg_type cfg_now = '{ctls_pkg::GREEN_TICKS_RST, ctls_pkg::AMBER_TICKS_RST,
                                  ctls_pkg::WALK_RED_TICKS_RST,
                                  ctls_pkg::PLAIN_RED_TICKS_RST,
                                  ctls_pkg::DUTY_CLOSED_RST, ctls_pkg::DUTY_OPEN_RST};
   ctls_pkg::phase_type cur_phase = ctls_pkg::PH_RED;
   logic [ctls_pkg::TICK_W-1:0] ticks_seen = '0;
   logic walk_request = 1'b0;
   ctls_pkg::lamp_type lamp_now = ctls_pkg::LAMP_OFF;
   logic walk_now = 1'b0;
   logic [ctls_pkg::DUTY_W-1:0] duty_now = ctls_pkg::DUTY_RST;
   int flash_steps = 0;
   logic flash_now = 1'b0;

   ctls_pkg::rsp_item_type expected_lights[$];
   int err_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   logic train_level = 1'b0;
   logic maint_level = 1'b0;

   function automatic void enter_phase(input ctls_pkg::phase_type p);
      cur_phase = p;
      ticks_seen = '0;
   endfunction

   function automatic logic [ctls_pkg::DUTY_W-1:0] pot_to_duty(input ctls_pkg::pot_type p);
      int unsigned full;
      int unsigned num;
      full = (1 << ctls_pkg::POT_BITS) - 1;
      num = cfg_now.duty_closed * (full - p) + cfg_now.duty_open * p + full / 2;
      return ctls_pkg::DUTY_W'(num / full);
   endfunction

   function automatic ctls_pkg::rsp_item_type next_lights(input ctls_pkg::req_item_type it);
      ctls_pkg::rsp_item_type lights;
      logic [ctls_pkg::TICK_W-1:0] dur;
      if (it.tick && ticks_seen != '1) ticks_seen = ticks_seen + 1'b1;
      if (it.ped_button) walk_request = 1'b1;
      if (it.maintenance_on && cur_phase != ctls_pkg::PH_MAINT) begin
         enter_phase(ctls_pkg::PH_MAINT);
         duty_now = cfg_now.duty_closed;
      end else if (it.train_present && cur_phase < ctls_pkg::PH_CLOSING) begin
         enter_phase(ctls_pkg::PH_CLOSING);
      end
      case (cur_phase) inside
         ctls_pkg::PH_RED: begin
            dur = walk_request ? cfg_now.walk_red_ticks : cfg_now.plain_red_ticks;
            lamp_now = ctls_pkg::LAMP_RED;
            duty_now = cfg_now.duty_open;
            walk_now = walk_request;
            if (ticks_seen >= dur) begin
               if (walk_request) begin
                  walk_request = 1'b0;
                  walk_now = 1'b0;
               end
               enter_phase(ctls_pkg::PH_YEL1);
            end
         end
         ctls_pkg::PH_YEL1, ctls_pkg::PH_YEL2: begin
            lamp_now = ctls_pkg::LAMP_YELLOW;
            if (ticks_seen >= cfg_now.amber_ticks)
               enter_phase(cur_phase == ctls_pkg::PH_YEL1 ? ctls_pkg::PH_GREEN
                                                          : ctls_pkg::PH_RED);
         end
         ctls_pkg::PH_GREEN: begin
            lamp_now = ctls_pkg::LAMP_GREEN;
            duty_now = cfg_now.duty_open;
            if (ticks_seen >= cfg_now.green_ticks) enter_phase(ctls_pkg::PH_YEL2);
         end
         ctls_pkg::PH_CLOSING: begin
            lamp_now = ctls_pkg::LAMP_RED;
            duty_now = cfg_now.duty_closed;
            enter_phase(ctls_pkg::PH_CLOSED);
         end
         ctls_pkg::PH_CLOSED: begin
            walk_now = 1'b1;
            if (!it.train_present) enter_phase(ctls_pkg::PH_OPENING);
         end
         ctls_pkg::PH_OPENING: begin
            duty_now = cfg_now.duty_open;
            enter_phase(ctls_pkg::PH_WAIT);
         end
         ctls_pkg::PH_WAIT: begin
            walk_now = 1'b1;
            if (ticks_seen >= cfg_now.walk_red_ticks) begin
               walk_now = 1'b0;
               enter_phase(ctls_pkg::PH_YEL1);
            end
         end
         default: begin
            lamp_now = ctls_pkg::LAMP_OFF;
            walk_now = 1'b1;
            duty_now = (ticks_seen == 0) ? cfg_now.duty_closed : pot_to_duty(it.pot_sample);
            if (!it.maintenance_on) begin
               walk_now = 1'b0;
               enter_phase(ctls_pkg::PH_RED);
            end
         end
      endcase
      if (it.maintenance_on && flash_steps == 0) begin
         lamp_now = ctls_pkg::LAMP_OFF;
         flash_now = !flash_now;
      end
      flash_steps = (flash_steps + 1 >= ctls_pkg::FLASH_PERIOD) ? 0 : flash_steps + 1;
      lights.phase = cur_phase;
      lights.lamp = lamp_now;
      lights.walk_led = walk_now;
      lights.gate_duty = duty_now;
      lights.flash_led = flash_now;
      return lights;
   endfunction

   task automatic report_error(input string what, input int unsigned want_v,
                               input int unsigned got_v);
      err_count++;
      if (err_count <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
   endtask

   // item acceptance feeds the prediction; results are checked in arrival order
   always @(posedge clock) begin
      ctls_pkg::rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_lights.push_back(next_lights(req_item));
         if (rsp_valid && rsp_ready) begin
            if (expected_lights.size() == 0) begin
               report_error("unexpected result", 0, 1);
            end else begin
               want = expected_lights.pop_front();
               if (rsp_item.phase !== want.phase)
                  report_error("phase", want.phase, rsp_item.phase);
               if (rsp_item.lamp !== want.lamp)
                  report_error("lamp", want.lamp, rsp_item.lamp);
               if (rsp_item.walk_led !== want.walk_led)
                  report_error("walk_led", want.walk_led, rsp_item.walk_led);
               if (rsp_item.gate_duty !== want.gate_duty)
                  report_error("gate_duty", want.gate_duty, rsp_item.gate_duty);
               if (rsp_item.flash_led !== want.flash_led)
                  report_error("flash_led", want.flash_led, rsp_item.flash_led);
            end
         end
      end
   end

   // result receiver with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic ctls_pkg::req_item_type mk(input logic tick, input logic btn,
                                                 input logic train, input logic maint,
                                                 input ctls_pkg::pot_type pot);
      ctls_pkg::req_item_type it;
      it.tick = tick;
      it.ped_button = btn;
      it.train_present = train;
      it.maintenance_on = maint;
      it.pot_sample = pot;
      return it;
   endfunction

   task automatic send_item(input ctls_pkg::req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_lights.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all six registers on consecutive cycles; junk fills the unused duty bits
   task automatic write_config(input ctls_pkg::cfg_type c, input logic [4:0] junk);
      logic [ctls_pkg::CSR_IDX_W-1:0] idxs [6];
      logic [ctls_pkg::CSR_DATA_W-1:0] vals [6];
      idxs = '{ctls_pkg::CSR_GREEN_TICKS, ctls_pkg::CSR_AMBER_TICKS,
               ctls_pkg::CSR_WALK_RED_TICKS, ctls_pkg::CSR_PLAIN_RED_TICKS,
               ctls_pkg::CSR_DUTY_CLOSED, ctls_pkg::CSR_DUTY_OPEN};
      vals = '{c.green_ticks, c.amber_ticks, c.walk_red_ticks, c.plain_red_ticks,
               {junk, c.duty_closed}, {~junk, c.duty_open}};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_now = c;
      @(posedge clock);
   endtask

   function automatic logic [ctls_pkg::TICK_W-1:0] random_duration();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return '1;
      if (r < 16) return '0;
      return ctls_pkg::TICK_W'($urandom_range(6, 1));
   endfunction

   // mostly plausible traffic: level-like train and maintenance, some noise
   function automatic ctls_pkg::req_item_type random_item();
      ctls_pkg::req_item_type it;
      logic [$bits(ctls_pkg::req_item_type)-1:0] raw;
      int unsigned r;
      if ($urandom_range(99) < 8) train_level = !train_level;
      if ($urandom_range(99) < 4) maint_level = !maint_level;
      if ($urandom_range(99) < 10) begin
         raw = $bits(ctls_pkg::req_item_type)'($urandom);
         it = raw;
      end else begin
         r = $urandom_range(99);
         it = mk($urandom_range(99) < 70, $urandom_range(99) < 10, train_level, maint_level,
                 r < 20 ? 12'h000 : r < 40 ? 12'hFFF
                                           : ctls_pkg::pot_type'($urandom_range(4095)));
      end
      return it;
   endfunction

   task automatic test_reset_defaults();
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b1, 1'b0, 1'b0, 12'hFFF));
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b1, 12'h555));
      wait_idle();
   endtask

   // zero and short durations, train sequence, maintenance, reversed duty range
   task automatic test_phase_walk();
      write_config('{16'd1, 16'd0, 16'd2, 16'd0, 11'd2047, 11'd0}, 5'h00);
      send_item(mk(1'b1, 1'b1, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b0, 1'b1, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b1, 1'b0, 12'h000));
      send_item(mk(1'b0, 1'b0, 1'b1, 1'b0, 12'hFFF));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b0, 12'h000));
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b1, 12'hFFF));
      send_item(mk(1'b1, 1'b0, 1'b0, 1'b1, 12'hFFF));
      send_item(mk(1'b1, 1'b0, 1'b1, 1'b1, 12'h000));
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b1, 12'h800));
      send_item(mk(1'b1, 1'b1, 1'b0, 1'b1, 12'h7FF));
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b0, 12'hFFF));
      send_item(mk(1'b1, 1'b0, 1'b1, 1'b1, 12'h000));
      send_item(mk(1'b0, 1'b0, 1'b1, 1'b0, 12'h000));
      send_item(mk(1'b0, 1'b0, 1'b1, 1'b0, 12'h000));
      send_item(mk(1'b1, 1'b1, 1'b0, 1'b0, 12'hABC));
      wait_idle();
   endtask

   // long maintenance run: gate follows the pot, flash LED keeps flashing
   task automatic test_long_maintenance();
      write_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd0, 11'd2047}, 5'h1F);
      for (int i = 0; i < 60; i++)
         send_item(mk(1'b1, i[4], 1'b0, 1'b1, ctls_pkg::pot_type'($urandom_range(4095, 16))));
      send_item(mk(1'b0, 1'b0, 1'b0, 1'b0, 12'h000));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int n, input int idle, input int stall);
      ctls_pkg::cfg_type c;
      c.green_ticks = random_duration();
      c.amber_ticks = random_duration();
      c.walk_red_ticks = random_duration();
      c.plain_red_ticks = random_duration();
      c.duty_closed = ctls_pkg::DUTY_W'($urandom_range(2047));
      c.duty_open = ctls_pkg::DUTY_W'($urandom_range(2047));
      write_config(c, 5'($urandom_range(31)));
      send_idle_pct = idle;
      stall_pct <= stall;
      for (int i = 0; i < n; i++) send_item(random_item());
      wait_idle();
   endtask

   // receiver held off while items keep coming, so the input side stalls
   task automatic test_input_backpressure();
      send_idle_pct = 0;
      stall_pct <= 0;
      hold_token <= hold_token + 1;
      for (int i = 0; i < 50; i++) send_item(random_item());
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_phase_walk();
      test_long_maintenance();
      test_random_traffic(130, 0, 0);
      test_random_traffic(130, 70, 0);
      test_random_traffic(130, 0, 70);
      test_random_traffic(130, 38, 38);
      test_input_backpressure();
      repeat (8) @(posedge clock);
      if (err_count == 0 && expected_lights.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/ctls_pkg.sv
rtl/ctls_csr_regs.sv
rtl/ctls_pot_map.sv
rtl/ctls_seq_core.sv
rtl/crossing_traffic_light_sequencer.sv
tb/crossing_traffic_light_sequencer_tb.sv
